>>> rtl/dpf_pkg.sv
`default_nettype none
package dpf_pkg;

  localparam int NumBins   = 64;
  localparam int LastBin   = NumBins - 1;
  localparam int Chunk     = 8;
  localparam int PhaseStgs = 8;
  localparam int NumStages = 3 * PhaseStgs;
  localparam int MaxWidth  = 31;
  localparam int SplitLen  = 32;

  typedef struct packed {
    logic [5:0] p1x;
    logic [4:0] p1w;
    logic [5:0] p2x;
    logic [4:0] p2w;
    logic       d1;
    logic       d2;
    logic       skip;
  } finder_t;

  // clamp a 7-bit signed difference the way the width rules want
  function automatic logic [4:0] clamp_w(input logic [6:0] diff);
    logic [4:0] r;
    r = diff[4:0];
    if (!diff[6] && (diff >= 7'(SplitLen))) r = 5'(MaxWidth);
    return r;
  endfunction

  function automatic finder_t close_at(input finder_t f, input logic [5:0] e);
    finder_t    r;
    logic [6:0] diff;
    r = f;
    if (f.skip) begin
      r.skip = 1'b0;
    end else if (!f.d1 && !f.d2) begin
      diff = {1'b0, e} - {1'b0, f.p1x};
      r.d1 = 1'b1;
      r.p1w = diff[4:0];
      if (!diff[6] && (diff >= 7'(SplitLen))) begin
        r.p2x = f.p1x + 6'(MaxWidth);
        r.p2w = 5'(diff - 7'(MaxWidth));
        r.d2  = 1'b1;
        r.p1w = 5'(MaxWidth);
      end
    end else if (f.d1 && !f.d2) begin
      diff = {1'b0, e} - {1'b0, f.p2x};
      r.p2w = clamp_w(diff);
      r.d2  = 1'b1;
    end
    return r;
  endfunction

  function automatic finder_t close_open(input finder_t f);
    finder_t r;
    r = f;
    if (f.skip) begin
      r.skip = 1'b0;
    end else if (!f.d1 && !f.d2) begin
      r.p1w = 5'd1;
      r.d1  = 1'b1;
      if (f.p1x <= 6'(NumBins - SplitLen)) begin
        r.p2x = f.p1x + 6'(MaxWidth);
        r.p2w = 5'd1;
        r.d2  = 1'b1;
        r.p1w = 5'(MaxWidth);
      end
    end else if (f.d1 && !f.d2) begin
      r.p2w = 5'd1;
      r.d2  = 1'b1;
      if (f.p2x <= 6'(NumBins - SplitLen)) r.p2w = 5'(MaxWidth);
    end
    return r;
  endfunction

  // gap filling, in place, one chunk of bins
  function automatic logic [NumBins-1:0] gap_chunk(input logic [NumBins-1:0] w,
                                                   input int s);
    logic [NumBins-1:0] b;
    int i;
    b = w;
    for (int k = 0; k < Chunk; k++) begin
      i = 2 + s * Chunk + k;
      if (i < LastBin) begin
        if (b[i-2] && b[i-1] && !b[i] && b[i+1]) b[i] = 1'b1;
        if (b[i-2] && !b[i-1] && b[i] && b[i+1]) b[i-1] = 1'b1;
      end
    end
    return b;
  endfunction

  // isolated-bin removal, in place, one chunk with the end rules
  function automatic logic [NumBins-1:0] rem_chunk(input logic [NumBins-1:0] w,
                                                   input int s);
    logic [NumBins-1:0] b;
    int i;
    b = w;
    if (s == 0) begin
      if (b[0] && !b[1]) b[0] = 1'b0;
    end
    for (int k = 0; k < Chunk; k++) begin
      i = 1 + s * Chunk + k;
      if (i < LastBin) begin
        if (!b[i-1] && b[i] && !b[i+1]) b[i] = 1'b0;
      end
    end
    if (s == PhaseStgs - 1) begin
      if (!b[LastBin-1] && b[LastBin]) b[LastBin] = 1'b0;
    end
    return b;
  endfunction

  // edge scan over one chunk
  function automatic finder_t scan_chunk(input logic [NumBins-1:0] b,
                                         input finder_t f, input int s);
    finder_t r;
    int i;
    r = f;
    if (s == 0) begin
      if (b[0] && b[1]) r.skip = 1'b1;
      else if (!b[0] && b[1] && b[2]) r.p1x = 6'd1;
    end
    for (int k = 0; k < Chunk; k++) begin
      i = 2 + s * Chunk + k;
      if (i < LastBin) begin
        if (!b[i-2] && !b[i-1] && b[i] && b[i+1]) begin
          if (!r.d1 && !r.d2) r.p1x = 6'(i);
          else if (r.d1 && !r.d2) r.p2x = 6'(i);
        end else if (b[i-2] && b[i-1] && !b[i] && !b[i+1]) begin
          r = close_at(r, 6'(i));
        end
      end
    end
    if (s == PhaseStgs - 1) begin
      if (b[LastBin-2] && b[LastBin-1] && !b[LastBin]) r = close_at(r, 6'(LastBin));
      else if (b[LastBin-1] && b[LastBin]) r = close_open(r);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/discriminator_pulse_finder.sv
// The result is read from the last stage's registers once the waveform has passed every stage.
// Throughput: one waveform per cycle; the whole pipe stalls while a
// result waits at the output.
// Stages 0-7 fill gaps, 8-15 remove isolated bins, 16-23 scan edges.
// Reset (rst_ni low, async) clears all stage valid bits.
`default_nettype none
module discriminator_pulse_finder import dpf_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [63:0] waveform_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [5:0]       first_position_o,
  output logic [4:0]       first_width_o,
  output logic [5:0]       second_position_o,
  output logic [4:0]       second_width_o
);

  logic [NumBins-1:0] wave_q [NumStages];
  finder_t            fin_q  [NumStages];
  logic [NumStages-1:0] vld_q;
  logic adv;

  assign adv        = !vld_q[NumStages-1] || out_ready_i;
  assign in_ready_o = adv;

  for (genvar s = 0; s < NumStages; s++) begin : g_stage
    logic [NumBins-1:0] wave_in, wave_d;
    finder_t            fin_in, fin_d;
    logic               vld_in;

    if (s == 0) begin : g_first
      assign wave_in = waveform_i;
      assign fin_in  = '0;
      assign vld_in  = in_valid_i;
    end else begin : g_next
      assign wave_in = wave_q[s-1];
      assign fin_in  = fin_q[s-1];
      assign vld_in  = vld_q[s-1];
    end

    always_comb begin
      wave_d = wave_in;
      fin_d  = fin_in;
      if (s < PhaseStgs) begin
        wave_d = gap_chunk(wave_in, s);
      end else if (s < 2 * PhaseStgs) begin
        wave_d = rem_chunk(wave_in, s - PhaseStgs);
      end else begin
        fin_d = scan_chunk(wave_in, fin_in, s - 2 * PhaseStgs);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (adv) begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        wave_q[s] <= wave_d;
        fin_q[s]  <= fin_d;
      end
    end
  end

  assign out_valid_o       = vld_q[NumStages-1];
  assign first_position_o  = fin_q[NumStages-1].p1x;
  assign first_width_o     = fin_q[NumStages-1].p1w;
  assign second_position_o = fin_q[NumStages-1].p2x;
  assign second_width_o    = fin_q[NumStages-1].p2w;

endmodule
`default_nettype wire
